// ----- hdl/slpc_pkg.sv -----
// ----------------------------------------------------------------------------
// slpc_pkg
// Shared types, codes and pattern tables for the status LED colour sequencer.
// ----------------------------------------------------------------------------
package slpc_pkg;

   // command codes
   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_MODE    = 3'd1;
   localparam logic [2:0] CMD_WR_BEG  = 3'd2;
   localparam logic [2:0] CMD_WR_END  = 3'd3;
   localparam logic [2:0] CMD_ERROR   = 3'd4;
   localparam logic [2:0] CMD_TRIGGER = 3'd5;

   // base modes
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_MACRO  = 2'd1;
   localparam logic [1:0] MODE_TASK   = 2'd2;
   localparam logic [1:0] MODE_UPLOAD = 2'd3;

   localparam int          DIV_W      = 24;
   localparam logic [15:0] SCALE_DIV  = 16'd65025;
   localparam logic [23:0] SCALE_RND  = 24'd32512;
   localparam logic [31:0] T_STARTUP  = 32'd1500;
   localparam logic [31:0] T_SUCCESS  = 32'd800;
   localparam logic [31:0] T_ERROR    = 32'd1800;
   localparam logic [31:0] T_TRIGGER  = 32'd450;
   localparam logic [31:0] T_WR_HOLD  = 32'd240;
   localparam logic [31:0] T_FLASH    = 32'd180;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_STARTUP = 3'd1,
      EV_SUCCESS = 3'd2,
      EV_ERROR   = 3'd3,
      EV_TRIGGER = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      PAT_SOLID,
      PAT_WRITE,
      PAT_SUCCESS,
      PAT_ERROR,
      PAT_UPLOAD
   } pattern_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_MUL1,
      S_MUL2,
      S_DIV,
      S_LOAD
   } state_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] now_ms;
      logic [1:0]  base_mode;
      logic        write_ok;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       send;
   } rsp_type;

   // blink period of each pattern
   function automatic logic [10:0] pat_period(input pattern_type pat);
      logic [10:0] m;
      unique case (pat)
         PAT_SUCCESS: m = 11'd800;
         PAT_ERROR:   m = 11'd1800;
         PAT_UPLOAD:  m = 11'd900;
         default:     m = 11'd240;
      endcase
      return m;
   endfunction

   // intensity for a phase within the period
   function automatic logic [7:0] pat_level(input pattern_type pat,
                                            input logic [10:0] p,
                                            input logic [7:0] solid);
      logic [7:0] lv;
      unique case (pat)
         PAT_WRITE:   lv = (p < 11'd120) ? 8'd255 : 8'd18;
         PAT_SUCCESS: lv = (p < 11'd140 || (p >= 11'd300 && p < 11'd440))
                           ? 8'd230 : 8'd8;
         PAT_ERROR:   lv = (p < 11'd130 || (p >= 11'd280 && p < 11'd410) ||
                            (p >= 11'd560 && p < 11'd690)) ? 8'd255 : 8'd5;
         PAT_UPLOAD:  lv = (p < 11'd120 || (p >= 11'd260 && p < 11'd380))
                           ? 8'd230 : 8'd8;
         default:     lv = solid;
      endcase
      return lv;
   endfunction

endpackage

// ----- hdl/status_led_pattern_controller.sv -----
// ----------------------------------------------------------------------------
// status_led_pattern_controller
// Status LED colour sequencer: time-stamped commands in, scaled colour out.
// ----------------------------------------------------------------------------
// Non-tick commands are accepted in the idle state and leave the sequencer
// idle. A tick's colour word reaches the output register after the tick has
// passed through S_MOD (32 steps in the bit-serial period remainder unit),
// S_MUL1 (channel products), S_MUL2 (divider start), S_DIV (24 steps in the
// bit-serial brightness divider) and S_LOAD. req_stall is high meanwhile, and
// longer while rsp_stall holds back the load, so a new tick is taken only once
// the last word is loaded. The output register holds a finished word while the
// next command is taken. csr_ready is always high; write brightness only while no tick is in flight.
module status_led_pattern_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  slpc_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output slpc_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_data
);
   import slpc_pkg::*;

   state_type   state_ff, state_in;
   logic [7:0]  bright_ff, bright_in;
   logic [1:0]  mode_ff, mode_in;
   logic [31:0] mode_since_ff, mode_since_in;
   event_type   ev_ff, ev_in;
   logic [31:0] ev_since_ff, ev_since_in;
   logic [31:0] ev_dl_ff, ev_dl_in;
   logic        writing_ff, writing_in;
   logic        pend_ff, pend_in;
   logic [31:0] wr_since_ff, wr_since_in;
   logic [31:0] wr_dl_ff, wr_dl_in;
   logic [23:0] last_ff, last_in;
   pattern_type pat_ff, pat_in;
   logic [2:0][7:0]  colour_ff, colour_in;
   logic [7:0]  solid_ff, solid_in;
   logic [7:0]  level_ff;
   logic [2:0][15:0] prod_ff;
   logic [2:0][DIV_W-1:0] div_arg;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   logic        accept, is_tick, out_free, cfg_wr;
   logic        mod_start, mod_done, mul1_en, div_start, div_done, load_en;
   logic [31:0] elapsed;
   logic [10:0] rem;
   logic [2:0][7:0] quo;
   logic [31:0] ev_t;
   logic [23:0] packed_col;

   assign accept   = req_valid && !req_stall;
   assign is_tick  = req_data.command == CMD_TICK;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cfg_wr   = csr_valid && csr_ready;
   assign csr_ready = 1'b1;

   // deadline checks by signed difference
   function automatic logic ev_dl_tick_before();
      logic [31:0] d;
      d = req_data.now_ms - ev_dl_ff;
      return d[31];
   endfunction

   function automatic logic wr_dl_tick_before();
      logic [31:0] d;
      d = req_data.now_ms - wr_dl_ff;
      return d[31];
   endfunction

   // command and brightness state update and render selection
   always_comb begin
      bright_in     = bright_ff;
      mode_in       = mode_ff;
      mode_since_in = mode_since_ff;
      ev_in         = ev_ff;
      ev_since_in   = ev_since_ff;
      ev_dl_in      = ev_dl_ff;
      writing_in    = writing_ff;
      pend_in       = pend_ff;
      wr_since_in   = wr_since_ff;
      wr_dl_in      = wr_dl_ff;
      pat_in        = pat_ff;
      colour_in     = colour_ff;
      solid_in      = solid_ff;
      elapsed       = '0;
      ev_t          = '0;
      if (cfg_wr) begin
         bright_in = csr_data;
      end
      if (accept) begin
         case (req_data.command)
            CMD_TICK: begin
               if (ev_ff != EV_NONE && !ev_dl_tick_before()) ev_in = EV_NONE;
               if (pend_ff && !wr_dl_tick_before()) begin
                  pend_in     = 1'b0;
                  ev_in       = EV_SUCCESS;
                  ev_since_in = req_data.now_ms;
                  ev_dl_in    = req_data.now_ms + T_SUCCESS;
               end
               ev_t     = req_data.now_ms - ev_since_in;
               solid_in = 8'd255;
               if (writing_ff || pend_in) begin
                  pat_in    = PAT_WRITE;
                  colour_in = {8'd0, 8'd120, 8'd255};
                  elapsed   = req_data.now_ms - wr_since_ff;
               end else if (ev_in != EV_NONE) begin
                  elapsed = ev_t;
                  unique case (ev_in)
                     EV_STARTUP: begin
                        pat_in    = PAT_SOLID;
                        colour_in = {8'd255, 8'd255, 8'd255};
                     end
                     EV_SUCCESS: begin
                        pat_in    = PAT_SUCCESS;
                        colour_in = {8'd40, 8'd255, 8'd0};
                     end
                     EV_ERROR: begin
                        pat_in    = PAT_ERROR;
                        colour_in = {8'd0, 8'd0, 8'd255};
                     end
                     default: begin
                        pat_in    = PAT_SOLID;
                        colour_in = {8'd255, 8'd255, 8'd255};
                        solid_in  = (ev_t < T_FLASH) ? 8'd255 : 8'd5;
                     end
                  endcase
               end else begin
                  pat_in = PAT_SOLID;
                  unique case (mode_ff)
                     MODE_IDLE:  colour_in = {8'd80, 8'd255, 8'd0};
                     MODE_MACRO: colour_in = {8'd255, 8'd220, 8'd0};
                     MODE_TASK:  colour_in = {8'd255, 8'd40, 8'd180};
                     default: begin
                        pat_in    = PAT_UPLOAD;
                        colour_in = {8'd255, 8'd100, 8'd30};
                        elapsed   = req_data.now_ms - mode_since_ff;
                     end
                  endcase
               end
            end
            CMD_MODE: begin
               if (req_data.base_mode != mode_ff) begin
                  mode_in       = req_data.base_mode;
                  mode_since_in = req_data.now_ms;
               end
            end
            CMD_WR_BEG: begin
               wr_since_in = req_data.now_ms;
               writing_in  = 1'b1;
               pend_in     = 1'b0;
               wr_dl_in    = '0;
            end
            CMD_WR_END: begin
               writing_in = 1'b0;
               if (!req_data.write_ok) begin
                  ev_in       = EV_ERROR;
                  ev_since_in = req_data.now_ms;
                  ev_dl_in    = req_data.now_ms + T_ERROR;
                  pend_in     = 1'b0;
               end else begin
                  pend_in  = 1'b1;
                  wr_dl_in = req_data.now_ms + T_WR_HOLD;
               end
            end
            CMD_ERROR: begin
               ev_in       = EV_ERROR;
               ev_since_in = req_data.now_ms;
               ev_dl_in    = req_data.now_ms + T_ERROR;
               writing_in  = 1'b0;
               pend_in     = 1'b0;
            end
            CMD_TRIGGER: begin
               if (!(ev_ff == EV_ERROR && ev_dl_tick_before())) begin
                  ev_in       = EV_TRIGGER;
                  ev_since_in = req_data.now_ms;
                  ev_dl_in    = req_data.now_ms + T_TRIGGER;
               end
            end
            default: ;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept && is_tick) state_in = S_MOD;
         S_MOD:  if (mod_done) state_in = S_MUL1;
         S_MUL1: state_in = S_MUL2;
         S_MUL2: state_in = S_DIV;
         S_DIV:  if (div_done) state_in = S_LOAD;
         S_LOAD: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      mod_start = 1'b0;
      mul1_en   = 1'b0;
      div_start = 1'b0;
      load_en   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            mod_start = req_valid && is_tick;
         end
         S_MUL1: mul1_en = 1'b1;
         S_MUL2: div_start = 1'b1;
         S_LOAD: load_en = out_free;
         default: ;
      endcase
   end

   slpc_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (elapsed),
      .period    (pat_period(pat_in)),
      .done      (mod_done),
      .remainder (rem)
   );

   // channel products, then rounding offset into the divider
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         div_arg[i] = DIV_W'(prod_ff[i]) * DIV_W'(level_ff) + SCALE_RND;
      end
   end

   slpc_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_arg),
      .done     (div_done),
      .quotient (quo)
   );

   // lane 0 carries red, lane 2 blue
   assign packed_col = {quo[0], quo[1], quo[2]};

   // output word and last colour
   always_comb begin
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cfg_wr) last_in = 24'hFFFFFF;
      if (load_en) begin
         last_in      = packed_col;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         bright_ff     <= 8'd255;
         mode_ff       <= MODE_IDLE;
         mode_since_ff <= '0;
         ev_ff         <= EV_STARTUP;
         ev_since_ff   <= '0;
         ev_dl_ff      <= T_STARTUP;
         writing_ff    <= 1'b0;
         pend_ff       <= 1'b0;
         wr_since_ff   <= '0;
         wr_dl_ff      <= '0;
         last_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bright_ff     <= bright_in;
         mode_ff       <= mode_in;
         mode_since_ff <= mode_since_in;
         ev_ff         <= ev_in;
         ev_since_ff   <= ev_since_in;
         ev_dl_ff      <= ev_dl_in;
         writing_ff    <= writing_in;
         pend_ff       <= pend_in;
         wr_since_ff   <= wr_since_in;
         wr_dl_ff      <= wr_dl_in;
         last_ff       <= last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pat_ff    <= pat_in;
      colour_ff <= colour_in;
      solid_ff  <= solid_in;
      if (mod_done) level_ff <= pat_level(pat_ff, rem, solid_ff);
      if (mul1_en) begin
         for (int i = 0; i < 3; i++) prod_ff[i] <= colour_ff[i] * bright_ff;
      end
      if (load_en) begin
         rsp_ff.red   <= quo[0];
         rsp_ff.green <= quo[1];
         rsp_ff.blue  <= quo[2];
         rsp_ff.send  <= packed_col != last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ----- hdl/slpc_mod_unit.sv -----
// ----------------------------------------------------------------------------
// slpc_mod_unit
// Bit-serial remainder of a 32-bit elapsed time by a small period.
// ----------------------------------------------------------------------------
module slpc_mod_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [10:0] period,
   output logic        done,
   output logic [10:0] remainder
);
   logic [31:0] shift_ff, shift_in;
   logic [10:0] rem_ff, rem_in;
   logic [10:0] per_ff, per_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [11:0] trial;

   // one dividend bit per cycle, msb first
   always_comb begin
      trial    = {rem_ff, shift_ff[31]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      per_in   = per_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         per_in   = period;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[30:0], 1'b0};
         rem_in   = (trial >= {1'b0, per_ff}) ? 11'(trial - {1'b0, per_ff})
                                              : trial[10:0];
         cnt_in   = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      per_ff   <= per_in;
      cnt_ff   <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

// ----- hdl/slpc_div_unit.sv -----
// ----------------------------------------------------------------------------
// slpc_div_unit
// Three-lane bit-serial divide by the full-scale constant for channel scaling.
// ----------------------------------------------------------------------------
module slpc_div_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [2:0][slpc_pkg::DIV_W-1:0]       dividend,
   output logic                                  done,
   output logic [2:0][7:0]                       quotient
);
   import slpc_pkg::*;

   logic [2:0][DIV_W-1:0] shift_ff, shift_in;
   logic [2:0][15:0]      rem_ff, rem_in;
   logic [2:0][7:0]       quo_ff, quo_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [2:0][16:0]      trial;
   logic [2:0]            fits;

   // restoring division, one quotient bit per lane per cycle
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         trial[i] = {rem_ff[i], shift_ff[i][DIV_W-1]};
         fits[i]  = trial[i] >= {1'b0, SCALE_DIV};
      end
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         quo_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 3; i++) begin
            shift_in[i] = {shift_ff[i][DIV_W-2:0], 1'b0};
            rem_in[i]   = fits[i] ? 16'(trial[i] - {1'b0, SCALE_DIV})
                                  : trial[i][15:0];
            quo_in[i]   = {quo_ff[i][6:0], fits[i]};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ----- tb/status_led_pattern_controller_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// status_led_pattern_controller_tb
// Checks every colour word of the LED sequencer against an in-bench predictor
// fed with directed and random time-stamped commands and brightness writes.
// ----------------------------------------------------------------------------
module status_led_pattern_controller_tb;
   import slpc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_data = 8'd0;

   always #2 clock = ~clock;

   status_led_pattern_controller u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // predictor state
   logic [7:0]  led_bright;
   logic [1:0]  led_mode;
   logic [31:0] led_mode_since;
   event_type   led_event;
   logic [31:0] led_ev_since, led_ev_dead;
   logic        led_writing, led_succ_pend;
   logic [31:0] led_wr_since, led_wr_dead;
   logic [23:0] led_last;

   rsp_type colour_q[$];
   int errors = 0;
   int words_seen = 0;
   int cmds_sent = 0;
   longint cycles = 0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch word %0d: %s got %0d want %0d", words_seen, what, got, want);
      errors++;
   endtask

   function automatic bit is_early(input logic [31:0] now, input logic [31:0] dl);
      logic [31:0] d;
      d = now - dl;
      return d[31];
   endfunction

   function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] lv);
      longint unsigned v;
      v = (longint'(c) * led_bright * lv + 32512) / 65025;
      return v[7:0];
   endfunction

   function automatic rsp_type paint(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic [7:0] lv);
      rsp_type o;
      o.red = scale(r, lv);
      o.green = scale(g, lv);
      o.blue = scale(b, lv);
      o.send = ({o.red, o.green, o.blue} != led_last);
      led_last = {o.red, o.green, o.blue};
      return o;
   endfunction

   function automatic void led_reset();
      led_bright = 8'd255; led_mode = MODE_IDLE; led_mode_since = 0;
      led_event = EV_STARTUP; led_ev_since = 0; led_ev_dead = T_STARTUP;
      led_writing = 0; led_succ_pend = 0; led_wr_since = 0; led_wr_dead = 0;
      led_last = 24'd0;
   endfunction

   function automatic void raise_error(input logic [31:0] now);
      led_event = EV_ERROR; led_ev_since = now; led_ev_dead = now + T_ERROR;
      led_writing = 0; led_succ_pend = 0;
   endfunction

   // advance predictor; returns 1 and the colour word for a tick
   function automatic bit led_step(input req_type q, output rsp_type o);
      logic [31:0] t, p;
      bit on;
      o = '0;
      case (q.command)
         CMD_TICK: begin
            if (led_event != EV_NONE && !is_early(q.now_ms, led_ev_dead))
               led_event = EV_NONE;
            if (led_succ_pend && !is_early(q.now_ms, led_wr_dead)) begin
               led_succ_pend = 0; led_event = EV_SUCCESS;
               led_ev_since = q.now_ms; led_ev_dead = q.now_ms + T_SUCCESS;
            end
            if (led_writing || led_succ_pend) begin
               p = (q.now_ms - led_wr_since) % 240;
               o = paint(255, 120, 0, p < 120 ? 255 : 18);
            end else if (led_event != EV_NONE) begin
               t = q.now_ms - led_ev_since;
               case (led_event)
                  EV_STARTUP: o = paint(255, 255, 255, 255);
                  EV_SUCCESS: begin
                     p = t % 800; on = p < 140 || (p >= 300 && p < 440);
                     o = paint(0, 255, 40, on ? 230 : 8);
                  end
                  EV_ERROR: begin
                     p = t % 1800;
                     on = p < 130 || (p >= 280 && p < 410) || (p >= 560 && p < 690);
                     o = paint(255, 0, 0, on ? 255 : 5);
                  end
                  default: o = paint(255, 255, 255, t < 180 ? 255 : 5);
               endcase
            end else begin
               case (led_mode)
                  MODE_IDLE:  o = paint(0, 255, 80, 255);
                  MODE_MACRO: o = paint(0, 220, 255, 255);
                  MODE_TASK:  o = paint(180, 40, 255, 255);
                  default: begin
                     p = (q.now_ms - led_mode_since) % 900;
                     on = p < 120 || (p >= 260 && p < 380);
                     o = paint(30, 100, 255, on ? 230 : 8);
                  end
               endcase
            end
            return 1;
         end
         CMD_MODE: if (q.base_mode != led_mode) begin
            led_mode = q.base_mode; led_mode_since = q.now_ms;
         end
         CMD_WR_BEG: begin
            led_wr_since = q.now_ms; led_writing = 1; led_succ_pend = 0; led_wr_dead = 0;
         end
         CMD_WR_END: begin
            led_writing = 0;
            if (!q.write_ok) raise_error(q.now_ms);
            else begin
               led_succ_pend = 1; led_wr_dead = q.now_ms + T_WR_HOLD;
            end
         end
         CMD_ERROR: raise_error(q.now_ms);
         CMD_TRIGGER: if (!(led_event == EV_ERROR && is_early(q.now_ms, led_ev_dead))) begin
            led_event = EV_TRIGGER; led_ev_since = q.now_ms;
            led_ev_dead = q.now_ms + T_TRIGGER;
         end
         default: ;
      endcase
      return 0;
   endfunction

   // gap length: mostly short, sometimes long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 90);
   endfunction

   // send one command word, predict before acceptance; valid drops only for a gap
   task automatic send_cmd(input req_type q);
      rsp_type o;
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      if (led_step(q, o)) colour_q.push_back(o);
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (req_stall);
      cmds_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (colour_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_bright(input logic [7:0] b);
      drain();
      csr_valid <= 1'b1;
      csr_data <= b;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      led_bright = b;
      led_last = 24'hFFFFFF;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (colour_q.size() == 0) begin
            $display("unexpected colour word %0d", words_seen);
            errors++;
         end else begin
            w = colour_q.pop_front();
            if (rsp_data.red != w.red) report("red", rsp_data.red, w.red);
            if (rsp_data.green != w.green) report("green", rsp_data.green, w.green);
            if (rsp_data.blue != w.blue) report("blue", rsp_data.blue, w.blue);
            if (rsp_data.send != w.send) report("send", rsp_data.send, w.send);
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (cycles < 3000) rsp_stall <= 1'b0;
      else if (r < 70) rsp_stall <= 1'b0;
      else if (r < 97) rsp_stall <= 1'b1;
      else rsp_stall <= ~rsp_stall;
   end

   // timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   typedef struct {
      req_type q;
      bit      fixed;
      rsp_type want;
   } step_row;

   step_row plan[$];

   function automatic req_type mk(input logic [2:0] c, input logic [31:0] t,
                                  input logic [1:0] m, input logic ok);
      req_type q;
      q.command = c; q.now_ms = t; q.base_mode = m; q.write_ok = ok;
      return q;
   endfunction

   initial begin
      req_type q;
      rsp_type chk;
      logic [31:0] clk_ms;
      int kind;
      led_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: known results only where they are obvious
      plan.push_back('{mk(CMD_TICK, 0, 0, 0), 1, '{255, 255, 255, 1}});
      plan.push_back('{mk(CMD_TICK, 1499, 3, 1), 1, '{255, 255, 255, 0}});
      plan.push_back('{mk(CMD_TICK, 1500, 0, 0), 1, '{0, 255, 80, 1}});
      plan.push_back('{mk(3'd6, 1600, 3, 1), 0, '0});
      plan.push_back('{mk(3'd7, 1601, 2, 0), 0, '0});
      plan.push_back('{mk(CMD_MODE, 1700, MODE_MACRO, 0), 0, '0});
      plan.push_back('{mk(CMD_TICK, 1701, 0, 0), 1, '{0, 220, 255, 1}});
      plan.push_back('{mk(CMD_MODE, 1800, MODE_TASK, 0), 0, '0});
      plan.push_back('{mk(CMD_TICK, 1801, 0, 0), 1, '{180, 40, 255, 1}});
      plan.push_back('{mk(CMD_TICK, 1802, 0, 0), 1, '{180, 40, 255, 0}});
      plan.push_back('{mk(CMD_MODE, 2000, MODE_UPLOAD, 0), 0, '0});
      plan.push_back('{mk(CMD_MODE, 2100, MODE_UPLOAD, 0), 0, '0});
      plan.push_back('{mk(CMD_TICK, 2270, 0, 0), 0, '0});
      plan.push_back('{mk(CMD_WR_BEG, 3000, 0, 0), 0, '0});
      plan.push_back('{mk(CMD_TICK, 3130, 0, 0), 0, '0});
      plan.push_back('{mk(CMD_WR_END, 3200, 0, 1), 0, '0});
      plan.push_back('{mk(CMD_TICK, 3439, 0, 0), 0, '0});
      plan.push_back('{mk(CMD_TICK, 3440, 0, 0), 0, '0});
      plan.push_back('{mk(CMD_WR_BEG, 4000, 0, 0), 0, '0});
      plan.push_back('{mk(CMD_WR_END, 4010, 0, 0), 0, '0});
      plan.push_back('{mk(CMD_TICK, 4300, 0, 0), 1, '{255, 0, 0, 1}});
      plan.push_back('{mk(CMD_TRIGGER, 4400, 0, 0), 0, '0});
      plan.push_back('{mk(CMD_ERROR, 32'hFFFF_FF00, 0, 0), 0, '0});
      plan.push_back('{mk(CMD_TRIGGER, 32'h0000_0800, 0, 0), 0, '0});
      plan.push_back('{mk(CMD_TICK, 32'h0000_0810, 0, 0), 1, '{255, 255, 255, 1}});

      foreach (plan[i]) begin
         send_cmd(plan[i].q);
         if (plan[i].fixed) begin
            chk = colour_q[$];
            if (chk != plan[i].want) begin
               $display("directed row %0d: table and predictor disagree", i);
               errors++;
            end
         end
      end

      // random phases, each with its own brightness
      clk_ms = $urandom;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_bright(8'd0);
            1: write_bright(8'd255);
            2: write_bright(8'd1);
            default: write_bright(8'($urandom_range(0, 255)));
         endcase
         for (int n = 0; n < 90; n++) begin
            kind = $urandom_range(0, 99);
            clk_ms += (kind < 90) ? $urandom_range(0, 60) : $urandom;
            if (kind < 55) q = mk(CMD_TICK, clk_ms, 2'($urandom), 1'($urandom));
            else if (kind < 65) q = mk(CMD_MODE, clk_ms, 2'($urandom), 1'($urandom));
            else if (kind < 73) q = mk(CMD_WR_BEG, clk_ms, 2'($urandom), 1'($urandom));
            else if (kind < 83)
               q = mk(CMD_WR_END, clk_ms, 2'($urandom), $urandom_range(0, 3) != 0);
            else if (kind < 89) q = mk(CMD_ERROR, clk_ms, 2'($urandom), 1'($urandom));
            else if (kind < 97) q = mk(CMD_TRIGGER, clk_ms, 2'($urandom), 1'($urandom));
            else q = mk(3'($urandom_range(6, 7)), clk_ms, 2'($urandom), 1'($urandom));
            send_cmd(q);
         end
      end

      drain();
      $display("%0d commands sent, %0d colour words checked over 7 brightness settings",
               cmds_sent, words_seen);
      if (errors == 0 && colour_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
